/* hw/rtl/ffha_pkg.sv */
// Shared types, constants and helpers for the first-fit heap allocator.
// No dependencies; every other file but ffha_ram imports this package.
package ffha_pkg;

  localparam int unsigned HEAP_BYTES   = 262144;
  localparam int unsigned ALIGN_BYTES  = 8;
  localparam int unsigned HEADER_BYTES = 12;
  localparam int unsigned MAX_BLOCKS   = 16384;

  localparam int unsigned OFS_W = 18;  // pool offset / block size
  localparam int unsigned LEN_W = 19;  // lengths up to the whole pool
  localparam int unsigned IDX_W = $clog2(MAX_BLOCKS);
  localparam int unsigned CNT_W = IDX_W + 1;

  localparam logic [1:0] OP_MALLOC  = 2'd0;
  localparam logic [1:0] OP_FREE    = 2'd1;
  localparam logic [1:0] OP_CALLOC  = 2'd2;
  localparam logic [1:0] OP_REALLOC = 2'd3;

  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_NO_FIT  = 2'd1;
  localparam logic [1:0] ST_BAD_PTR = 2'd2;

  typedef struct packed {
    logic [1:0]       op;
    logic [31:0]      req_bytes;
    logic [31:0]      elem_count;
    logic             addr_null;
    logic [OFS_W-1:0] payload_addr;
  } in_t;

  typedef struct packed {
    logic [1:0]       status;
    logic             result_null;
    logic [OFS_W-1:0] result_addr;
    logic [LEN_W-1:0] copy_bytes;
    logic [LEN_W-1:0] zero_bytes;
  } out_t;

  typedef struct packed {
    logic [OFS_W-1:0] start;
    logic [OFS_W-1:0] size;
    logic             free;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  // Round a length up to the alignment grain.
  function automatic logic [LEN_W-1:0] round_up(input logic [LEN_W-1:0] n);
    logic [LEN_W-1:0] s;
    s = n + LEN_W'(ALIGN_BYTES - 1);
    return s & ~LEN_W'(ALIGN_BYTES - 1);
  endfunction

endpackage

/* hw/rtl/first_fit_heap_allocator.sv */
// Top level of the first-fit heap allocator: request sequencer around the block table.
// Depends on ffha_pkg and ffha_ram.
//
// Usage:
//   Raise start with a request beat on in_data; it is taken at an edge where
//   busy is low. busy then stays high until the request is finished.
//   Exactly one result beat follows, shown on out_data for a single cycle
//   while out_valid is high; the receiver cannot hold it off, so capture it.
//   The block table lives in one synchronous RAM (start, size, free mark per
//   entry). A request that touches the table walks it entry by entry:
//   first-fit search and address lookup read one entry at a time, a split
//   shifts the upper entries up one slot at a time, top first, and a free
//   compacts the table in one pass. After reset the block writes the initial
//   free block that covers the pool in state S_INIT; busy is high meanwhile.
//   Calloc multiplies count by size in the accept cycle and registers it.
module first_fit_heap_allocator (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  ffha_pkg::in_t  in_data,
  output logic           out_valid,
  output ffha_pkg::out_t out_data
);
  import ffha_pkg::*;

  localparam logic [3:0] S_INIT   = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_PREP   = 4'd2;
  localparam logic [3:0] S_SC_RD  = 4'd3;
  localparam logic [3:0] S_SC_EV  = 4'd4;
  localparam logic [3:0] S_HIT    = 4'd5;
  localparam logic [3:0] S_SH_RD  = 4'd6;
  localparam logic [3:0] S_SH_WR  = 4'd7;
  localparam logic [3:0] S_SP_W1  = 4'd8;
  localparam logic [3:0] S_SP_W0  = 4'd9;
  localparam logic [3:0] S_AFTER  = 4'd10;
  localparam logic [3:0] S_MG_RD0 = 4'd11;
  localparam logic [3:0] S_MG_L0  = 4'd12;
  localparam logic [3:0] S_MG_RD  = 4'd13;
  localparam logic [3:0] S_MG_EV  = 4'd14;
  localparam logic [3:0] S_DONE   = 4'd15;

  localparam logic [31:0]    HEAP32 = 32'(HEAP_BYTES);
  localparam logic [LEN_W:0] SPLIT_MARGIN = (LEN_W+1)'(HEADER_BYTES + ALIGN_BYTES);

  logic [3:0]       state_r, state_nxt;
  logic [1:0]       op_r, op_nxt;
  logic [31:0]      req_r, req_nxt;
  logic             anull_r, anull_nxt;
  logic [OFS_W-1:0] addr_r, addr_nxt;
  logic [63:0]      prod_r, prod_nxt;
  logic [LEN_W-1:0] wanted_r, wanted_nxt;
  logic             alloc_mode_r, alloc_mode_nxt;
  logic             move_r, move_nxt;
  logic             split_r, split_nxt;
  logic             keep_free_r, keep_free_nxt;
  logic [CNT_W-1:0] i_r, i_nxt;
  logic [CNT_W-1:0] j_r, j_nxt;
  logic [CNT_W-1:0] jw_r, jw_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  entry_t           ent_r, ent_nxt;
  entry_t           acc_r, acc_nxt;
  logic [OFS_W-1:0] old_r, old_nxt;
  logic [1:0]       status_r, status_nxt;
  logic             ok_r, ok_nxt;
  logic [OFS_W-1:0] res_r, res_nxt;
  logic [LEN_W-1:0] copy_r, copy_nxt;
  logic [LEN_W-1:0] zero_r, zero_nxt;
  logic             out_valid_r;
  out_t             out_data_r;

  logic             we;
  logic [IDX_W-1:0] waddr, raddr;
  entry_t           wdata, rd;
  logic [ENTRY_W-1:0] rdata_raw;

  logic             req_fits_pool;
  logic [LEN_W-1:0] req_round;
  logic             hit;
  logic [CNT_W-1:0] j_inc;

  ffha_ram #(.DEPTH(MAX_BLOCKS), .WIDTH(ENTRY_W)) u_table (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata_raw)
  );

  assign rd = entry_t'(rdata_raw);

  assign req_fits_pool = (req_r <= HEAP32);
  assign req_round     = round_up(req_r[LEN_W-1:0]);
  assign j_inc         = j_r + CNT_W'(1);

  // Match test of the search: a fitting free block, or the header that owns the address.
  always_comb begin
    if (alloc_mode_r) begin
      hit = rd.free && ({1'b0, rd.size} >= wanted_r);
    end else begin
      hit = (({1'b0, rd.start} + LEN_W'(HEADER_BYTES)) == {1'b0, addr_r});
    end
  end

  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    req_nxt        = req_r;
    anull_nxt      = anull_r;
    addr_nxt       = addr_r;
    prod_nxt       = prod_r;
    wanted_nxt     = wanted_r;
    alloc_mode_nxt = alloc_mode_r;
    move_nxt       = move_r;
    split_nxt      = split_r;
    keep_free_nxt  = keep_free_r;
    i_nxt          = i_r;
    j_nxt          = j_r;
    jw_nxt         = jw_r;
    count_nxt      = count_r;
    idx_nxt        = idx_r;
    ent_nxt        = ent_r;
    acc_nxt        = acc_r;
    old_nxt        = old_r;
    status_nxt     = status_r;
    ok_nxt         = ok_r;
    res_nxt        = res_r;
    copy_nxt       = copy_r;
    zero_nxt       = zero_r;
    we             = 1'b0;
    waddr          = idx_r;
    wdata          = ent_r;
    raddr          = i_r[IDX_W-1:0];

    unique case (state_r)
      S_INIT: begin
        // Lay down the single free block spanning the pool.
        we        = 1'b1;
        waddr     = '0;
        wdata     = '{start: '0, size: OFS_W'(HEAP_BYTES - HEADER_BYTES), free: 1'b1};
        count_nxt = CNT_W'(1);
        state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          op_nxt    = in_data.op;
          req_nxt   = in_data.req_bytes;
          anull_nxt = in_data.addr_null;
          addr_nxt  = in_data.payload_addr;
          prod_nxt  = 64'(in_data.elem_count) * 64'(in_data.req_bytes);
          state_nxt = S_PREP;
        end
      end
      S_PREP: begin
        status_nxt     = ST_DONE;
        ok_nxt         = 1'b0;
        res_nxt        = '0;
        copy_nxt       = '0;
        zero_nxt       = '0;
        move_nxt       = 1'b0;
        i_nxt          = '0;
        alloc_mode_nxt = 1'b0;
        case (op_r)
          OP_FREE: begin
            state_nxt = anull_r ? S_DONE : S_SC_RD;
          end
          OP_CALLOC: begin
            if (prod_r > 64'(HEAP_BYTES)) begin
              status_nxt = ST_NO_FIT;
              state_nxt  = S_DONE;
            end else if (prod_r == 64'd0) begin
              state_nxt = S_DONE;
            end else begin
              wanted_nxt     = round_up(prod_r[LEN_W-1:0]);
              alloc_mode_nxt = 1'b1;
              state_nxt      = S_SC_RD;
            end
          end
          default: begin
            if (op_r == OP_REALLOC && !anull_r) begin
              state_nxt = S_SC_RD;
            end else if (req_r != 32'd0 && req_fits_pool) begin
              wanted_nxt     = req_round;
              alloc_mode_nxt = 1'b1;
              state_nxt      = S_SC_RD;
            end else begin
              status_nxt = (req_r != 32'd0) ? ST_NO_FIT : ST_DONE;
              state_nxt  = S_DONE;
            end
          end
        endcase
      end
      S_SC_RD: begin
        if (i_r == count_r) begin
          // Walked off the table: nothing fits, or the address names no block.
          if (alloc_mode_r) begin
            status_nxt = ST_NO_FIT;
          end else if (!move_r) begin
            status_nxt = ST_BAD_PTR;
          end
          state_nxt = S_DONE;
        end else begin
          raddr     = i_r[IDX_W-1:0];
          state_nxt = S_SC_EV;
        end
      end
      S_SC_EV: begin
        if (hit) begin
          idx_nxt   = i_r[IDX_W-1:0];
          ent_nxt   = rd;
          state_nxt = S_HIT;
        end else begin
          i_nxt     = i_r + CNT_W'(1);
          state_nxt = S_SC_RD;
        end
      end
      S_HIT: begin
        j_nxt = count_r - CNT_W'(1);
        if (alloc_mode_r) begin
          keep_free_nxt = 1'b0;
          split_nxt = ({1'b0, 1'b0, ent_r.size} > ({1'b0, wanted_r} + SPLIT_MARGIN)) &&
                      (count_r < CNT_W'(MAX_BLOCKS));
          state_nxt = S_SH_RD;
        end else if (op_r == OP_FREE || move_r || req_r == 32'd0) begin
          // Mark free, then compact the table.
          we        = 1'b1;
          waddr     = idx_r;
          wdata     = '{start: ent_r.start, size: ent_r.size, free: 1'b1};
          state_nxt = S_MG_RD0;
        end else if (req_fits_pool && (req_round <= {1'b0, ent_r.size})) begin
          // Shrink in place; the free mark stays as it was.
          wanted_nxt    = req_round;
          keep_free_nxt = ent_r.free;
          ok_nxt        = 1'b1;
          res_nxt       = addr_r;
          split_nxt = ({1'b0, 1'b0, ent_r.size} > ({1'b0, req_round} + SPLIT_MARGIN)) &&
                      (count_r < CNT_W'(MAX_BLOCKS));
          state_nxt = S_SH_RD;
        end else begin
          old_nxt = ent_r.size;
          if (req_fits_pool) begin
            wanted_nxt     = req_round;
            alloc_mode_nxt = 1'b1;
            i_nxt          = '0;
            state_nxt      = S_SC_RD;
          end else begin
            status_nxt = ST_NO_FIT;
            state_nxt  = S_DONE;
          end
        end
      end
      S_SH_RD: begin
        // Shift entries above the split point up one slot, top first.
        if (!split_r) begin
          state_nxt = S_SP_W0;
        end else if (j_r == {1'b0, idx_r}) begin
          state_nxt = S_SP_W1;
        end else begin
          raddr     = j_r[IDX_W-1:0];
          state_nxt = S_SH_WR;
        end
      end
      S_SH_WR: begin
        we        = 1'b1;
        waddr     = j_inc[IDX_W-1:0];
        wdata     = rd;
        j_nxt     = j_r - CNT_W'(1);
        state_nxt = S_SH_RD;
      end
      S_SP_W1: begin
        we    = 1'b1;
        waddr = idx_r + IDX_W'(1);
        wdata = '{start: ent_r.start + OFS_W'(HEADER_BYTES) + wanted_r[OFS_W-1:0],
                  size:  ent_r.size - wanted_r[OFS_W-1:0] - OFS_W'(HEADER_BYTES),
                  free:  1'b1};
        count_nxt = count_r + CNT_W'(1);
        state_nxt = S_SP_W0;
      end
      S_SP_W0: begin
        we    = 1'b1;
        waddr = idx_r;
        wdata = '{start: ent_r.start,
                  size:  split_r ? wanted_r[OFS_W-1:0] : ent_r.size,
                  free:  keep_free_r};
        state_nxt = S_AFTER;
      end
      S_AFTER: begin
        if (alloc_mode_r) begin
          ok_nxt  = 1'b1;
          res_nxt = ent_r.start + OFS_W'(HEADER_BYTES);
          if (op_r == OP_CALLOC) begin
            zero_nxt = prod_r[LEN_W-1:0];
          end
          if (op_r == OP_REALLOC && !anull_r) begin
            // Moved: report the copy length, then free the old block.
            copy_nxt = ({14'd0, req_r} < {28'd0, old_r}) ? req_r[LEN_W-1:0]
                                                           : {1'b0, old_r};
            move_nxt       = 1'b1;
            alloc_mode_nxt = 1'b0;
            i_nxt          = '0;
            state_nxt      = S_SC_RD;
          end else begin
            state_nxt = S_DONE;
          end
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_MG_RD0: begin
        raddr     = '0;
        state_nxt = S_MG_L0;
      end
      S_MG_L0: begin
        acc_nxt   = rd;
        jw_nxt    = '0;
        i_nxt     = CNT_W'(1);
        state_nxt = S_MG_RD;
      end
      S_MG_RD: begin
        if (i_r == count_r) begin
          we        = 1'b1;
          waddr     = jw_r[IDX_W-1:0];
          wdata     = acc_r;
          count_nxt = jw_r + CNT_W'(1);
          state_nxt = S_DONE;
        end else begin
          raddr     = i_r[IDX_W-1:0];
          state_nxt = S_MG_EV;
        end
      end
      S_MG_EV: begin
        // Absorb a free neighbour, or retire the accumulated entry.
        if (acc_r.free && rd.free) begin
          acc_nxt.size = acc_r.size + OFS_W'(HEADER_BYTES) + rd.size;
        end else begin
          we      = 1'b1;
          waddr   = jw_r[IDX_W-1:0];
          wdata   = acc_r;
          jw_nxt  = jw_r + CNT_W'(1);
          acc_nxt = rd;
        end
        i_nxt     = i_r + CNT_W'(1);
        state_nxt = S_MG_RD;
      end
      S_DONE: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_INIT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      count_r     <= CNT_W'(1);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= (state_r == S_DONE);
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    req_r        <= req_nxt;
    anull_r      <= anull_nxt;
    addr_r       <= addr_nxt;
    prod_r       <= prod_nxt;
    wanted_r     <= wanted_nxt;
    alloc_mode_r <= alloc_mode_nxt;
    move_r       <= move_nxt;
    split_r      <= split_nxt;
    keep_free_r  <= keep_free_nxt;
    i_r          <= i_nxt;
    j_r          <= j_nxt;
    jw_r         <= jw_nxt;
    idx_r        <= idx_nxt;
    ent_r        <= ent_nxt;
    acc_r        <= acc_nxt;
    old_r        <= old_nxt;
    status_r     <= status_nxt;
    ok_r         <= ok_nxt;
    res_r        <= res_nxt;
    copy_r       <= copy_nxt;
    zero_r       <= zero_nxt;
    if (state_r == S_DONE) begin
      out_data_r <= '{status: status_r, result_null: !ok_r,
                      result_addr: ok_r ? res_r : '0,
                      copy_bytes: copy_r, zero_bytes: zero_r};
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* hw/rtl/ffha_ram.sv */
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module ffha_ram #(
  parameter int unsigned DEPTH = 16384,
  parameter int unsigned WIDTH = 37
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

/* tb/ffha_checker.sv */
// Watches the request and result channels of the first-fit heap allocator,
// predicts each result from its own copy of the block table and compares.
// Depends on ffha_pkg.
module ffha_checker (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic           busy,
  input  ffha_pkg::in_t  in_data,
  input  logic           out_valid,
  input  ffha_pkg::out_t out_data,
  output int             mismatches,
  output int             pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import ffha_pkg::*;

  logic [17:0] blk_start [MAX_BLOCKS];
  logic [17:0] blk_size [MAX_BLOCKS];
  logic        blk_free [MAX_BLOCKS];
  int unsigned nblocks;
  out_t        awaited_results[$];

  function automatic longint unsigned grain_up(longint unsigned n);
    return ((n + ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES;
  endfunction

  function automatic bit lookup(logic [17:0] pay, output int unsigned idx);
    idx = 0;
    for (int unsigned i = 0; i < nblocks; i++)
      if (longint'(blk_start[i]) + HEADER_BYTES == longint'(pay)) begin
        idx = i;
        return 1;
      end
    return 0;
  endfunction

  function automatic void carve(int unsigned i, longint unsigned want);
    if (longint'(blk_size[i]) <= want + HEADER_BYTES + ALIGN_BYTES) return;
    if (nblocks >= MAX_BLOCKS) return;
    for (int unsigned k = nblocks; k > i + 1; k--) begin
      blk_start[k] = blk_start[k-1];
      blk_size[k]  = blk_size[k-1];
      blk_free[k]  = blk_free[k-1];
    end
    blk_start[i+1] = 18'(blk_start[i] + HEADER_BYTES + want);
    blk_size[i+1]  = 18'(blk_size[i] - want - HEADER_BYTES);
    blk_free[i+1]  = 1'b1;
    blk_size[i]    = 18'(want);
    nblocks++;
  endfunction

  function automatic void coalesce();
    int unsigned j;
    j = 0;
    for (int unsigned i = 1; i < nblocks; i++) begin
      if (blk_free[j] && blk_free[i]) begin
        blk_size[j] = 18'(blk_size[j] + HEADER_BYTES + blk_size[i]);
      end else begin
        j++;
        blk_start[j] = blk_start[i];
        blk_size[j]  = blk_size[i];
        blk_free[j]  = blk_free[i];
      end
    end
    nblocks = j + 1;
  endfunction

  function automatic bit first_fit(longint unsigned sz, output logic [17:0] pay);
    longint unsigned want;
    pay = '0;
    if (sz == 0 || sz > HEAP_BYTES) return 0;
    want = grain_up(sz);
    for (int unsigned i = 0; i < nblocks; i++)
      if (blk_free[i] && longint'(blk_size[i]) >= want) begin
        carve(i, want);
        blk_free[i] = 1'b0;
        pay = 18'(blk_start[i] + HEADER_BYTES);
        return 1;
      end
    return 0;
  endfunction

  function automatic out_t predict_heap_op(in_t rq);
    out_t r;
    longint unsigned req, cnt, total, old;
    int unsigned idx;
    logic [17:0] pay;
    bit ok;
    r = '0;
    ok = 0;
    pay = '0;
    req = rq.req_bytes;
    cnt = rq.elem_count;
    case (rq.op)
      OP_MALLOC: begin
        ok = first_fit(req, pay);
        if (!ok && req != 0) r.status = ST_NO_FIT;
      end
      OP_FREE: begin
        if (!rq.addr_null) begin
          if (lookup(rq.payload_addr, idx)) begin
            blk_free[idx] = 1'b1;
            coalesce();
          end else r.status = ST_BAD_PTR;
        end
      end
      OP_CALLOC: begin
        if (req != 0 && cnt > HEAP_BYTES / req) r.status = ST_NO_FIT;
        else begin
          total = cnt * req;
          ok = first_fit(total, pay);
          if (ok) r.zero_bytes = 19'(total);
          else if (total != 0) r.status = ST_NO_FIT;
        end
      end
      default: begin
        if (rq.addr_null) begin
          ok = first_fit(req, pay);
          if (!ok && req != 0) r.status = ST_NO_FIT;
        end else if (!lookup(rq.payload_addr, idx)) r.status = ST_BAD_PTR;
        else if (req == 0) begin
          blk_free[idx] = 1'b1;
          coalesce();
        end else if (grain_up(req) <= longint'(blk_size[idx])) begin
          carve(idx, grain_up(req));
          ok = 1;
          pay = rq.payload_addr;
        end else begin
          old = blk_size[idx];
          ok = first_fit(req, pay);
          if (ok) begin
            r.copy_bytes = 19'(old < req ? old : req);
            if (lookup(rq.payload_addr, idx)) begin
              blk_free[idx] = 1'b1;
              coalesce();
            end
          end else r.status = ST_NO_FIT;
        end
      end
    endcase
    r.result_null = !ok;
    r.result_addr = ok ? pay : '0;
    return r;
  endfunction

  assign pending = awaited_results.size();

  always @(posedge clk) begin
    out_t want;
    if (!rst_n) begin
      blk_start[0] = '0;
      blk_size[0]  = 18'(HEAP_BYTES - HEADER_BYTES);
      blk_free[0]  = 1'b1;
      nblocks = 1;
      awaited_results.delete();
      mismatches = 0;
    end else begin
      if (out_valid) begin
        if (awaited_results.size() == 0) begin
          $display("%0t: unexpected result %p", $time, out_data);
          mismatches++;
        end else begin
          want = awaited_results.pop_front();
          if (out_data !== want) begin
            $display("%0t: expected %p actual %p", $time, want, out_data);
            mismatches++;
          end
        end
      end
      if (start && !busy) awaited_results.push_back(predict_heap_op(in_data));
    end
  end
endmodule

/* tb/tb_first_fit_heap_allocator.sv */
// Testbench top for the first-fit heap allocator: drives request beats with random
// gaps and gives the verdict. Depends on ffha_pkg, ffha_checker and the allocator.
module tb_first_fit_heap_allocator;
  timeunit 1ns;
  timeprecision 1ps;
  import ffha_pkg::*;

  logic  clk = 1'b0;
  logic  rst_n = 1'b0;
  logic  start = 1'b0;
  logic  busy, out_valid;
  in_t   in_data = '0;
  out_t  out_data;
  int    mismatches, pending;
  int    cycles = 0;
  // payload addresses handed out so far, reused to build free/realloc beats
  logic [17:0] live_ptrs[$];
  int    beats_sent = 0;

  always #10 clk = ~clk;

  first_fit_heap_allocator uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_data(in_data), .out_valid(out_valid), .out_data(out_data)
  );

  ffha_checker chk (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data),
    .mismatches(mismatches), .pending(pending)
  );

  // Harvest returned pointers so later beats name live blocks.
  always @(posedge clk)
    if (out_valid && !out_data.result_null && live_ptrs.size() < 64)
      live_ptrs.push_back(out_data.result_addr);

  // Abort on a hung block.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 2000000) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Present one beat and hold it until the block takes it; the caller drops start.
  task automatic send(logic [1:0] op, logic [31:0] req, logic [31:0] cnt,
                      logic anull, logic [17:0] addr);
    in_t b;
    b = '{op: op, req_bytes: req, elem_count: cnt, addr_null: anull,
          payload_addr: addr};
    start   <= 1'b1;
    in_data <= b;
    @(posedge clk);
    while (busy) @(posedge clk);
    beats_sent++;
  endtask

  function automatic logic [17:0] pick_ptr();
    if (live_ptrs.size() == 0 || $urandom_range(0, 9) == 0) return 18'($urandom);
    return live_ptrs[$urandom_range(0, live_ptrs.size() - 1)];
  endfunction

  initial begin
    logic [1:0]  op;
    logic [31:0] req;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: zero sizes, extremes, overflow, null and unknown pointers.
    send(OP_MALLOC, 32'd0, 32'd0, 1'b0, 18'd0);
    send(OP_MALLOC, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 18'h3FFFF);
    send(OP_MALLOC, HEAP_BYTES, 32'd0, 1'b0, 18'd0);
    send(OP_MALLOC, HEAP_BYTES - HEADER_BYTES, 32'd0, 1'b0, 18'd0);
    send(OP_FREE, 32'd0, 32'd0, 1'b0, 18'd12);
    send(OP_MALLOC, 32'd1, 32'd0, 1'b0, 18'd0);
    send(OP_MALLOC, 32'd100, 32'd0, 1'b0, 18'd0);
    send(OP_CALLOC, 32'd8, 32'd10, 1'b0, 18'd0);
    send(OP_CALLOC, 32'd0, 32'hFFFF_FFFF, 1'b0, 18'd0);
    send(OP_CALLOC, 32'hFFFF_FFFF, 32'd2, 1'b0, 18'd0);
    send(OP_CALLOC, 32'd4, 32'd65536, 1'b0, 18'd0);
    send(OP_FREE, 32'd0, 32'd0, 1'b1, 18'd0);
    send(OP_FREE, 32'd0, 32'd0, 1'b0, 18'd13);
    send(OP_FREE, 32'd0, 32'd0, 1'b0, 18'd12);
    send(OP_FREE, 32'd0, 32'd0, 1'b0, 18'd12);
    send(OP_REALLOC, 32'd40, 32'd0, 1'b1, 18'd0);
    send(OP_REALLOC, 32'd0, 32'd0, 1'b1, 18'd0);
    send(OP_REALLOC, 32'd16, 32'd0, 1'b0, 18'd24);
    send(OP_REALLOC, 32'd200000, 32'd0, 1'b0, 18'd24);
    send(OP_REALLOC, 32'd300000, 32'd0, 1'b0, 18'd24);
    send(OP_REALLOC, 32'd8, 32'd0, 1'b0, 18'd12);
    send(OP_REALLOC, 32'd0, 32'd0, 1'b0, 18'd24);
    send(OP_REALLOC, 32'd8, 32'd0, 1'b0, 18'h3FFFF);

    // Random: mostly well-formed traffic on live pointers, some noise.
    for (int n = 0; n < 100; n++) begin
      if (n < 85 && $urandom_range(0, 3) == 0) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
      op = 2'($urandom);
      case ($urandom_range(0, 9))
        0: req = $urandom;
        1: req = $urandom_range(0, HEAP_BYTES);
        default: req = $urandom_range(0, 4000);
      endcase
      if (op == OP_CALLOC)
        send(op, $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 64),
             $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 64),
             1'($urandom), 18'($urandom));
      else
        send(op, req, $urandom, $urandom_range(0, 7) == 0, pick_ptr());
    end
    start <= 1'b0;

    // Drain, then allow for the last beat's table walk.
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("Covered %0d request beats: malloc, free, calloc and realloc", beats_sent);
    $display("with null, unknown, oversized and overflowing requests.");
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule
